/* design/scan_code_to_ascii_converter_core_defines.svh */
// ----------------------------------------------------------------------------
// scan code converter assertion macros
// concurrent check wrappers, clocked on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SCAN_CODE_TO_ASCII_CONVERTER_CORE_DEFINES_SVH
`define SCAN_CODE_TO_ASCII_CONVERTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SC2A_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`define SC2A_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SC2A_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SC2A_ASSERT_NEVER(label, cond, msg)
`define SC2A_ASSERT_IMPL(label, ante, cons, msg)
`define SC2A_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/sc2a_pkg.sv */
// ----------------------------------------------------------------------------
// sc2a_pkg
// shared types, constants and key map tables of the set-1 scan code converter
// ----------------------------------------------------------------------------
package sc2a_pkg;

	localparam int IDX_W        = 7;
	localparam int MAP_ENTRIES  = 89;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [1:0] PAUSE_SKIP_COUNT = 2'd2;

	localparam logic [7:0] SC_PAUSE_PREFIX  = 8'hE1;
	localparam logic [7:0] SC_EXTEND_PREFIX = 8'hE0;
	localparam logic [7:0] CODE_PAUSE       = 8'hA0;
	localparam logic [7:0] CODE_NONE        = 8'h00;
	localparam logic [7:0] ASCII_LOWER_A    = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z    = 8'h7A;

	localparam logic [IDX_W-1:0] IDX_LSHIFT    = 7'd42;
	localparam logic [IDX_W-1:0] IDX_RSHIFT    = 7'd54;
	localparam logic [IDX_W-1:0] IDX_CAPS      = 7'd58;
	localparam logic [IDX_W-1:0] IDX_NUM       = 7'd69;
	localparam logic [IDX_W-1:0] IDX_SCROLL    = 7'd70;
	localparam logic [IDX_W-1:0] IDX_SYM_FIRST = 7'd2;
	localparam logic [IDX_W-1:0] IDX_SYM_LAST  = 7'd53;
	localparam logic [IDX_W-1:0] IDX_KP_FIRST  = 7'd71;
	localparam logic [IDX_W-1:0] IDX_KP_LAST   = 7'd83;

	localparam logic [7:0] NORMAL_ROM [MAP_ENTRIES] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h81, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h83, 8'h2A,
		8'h85, 8'h20, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
		8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93,
		8'h94, 8'h95, 8'h2D, 8'h96, 8'h97, 8'h98, 8'h2B, 8'h99,
		8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h00, 8'h00, 8'h00, 8'h9E,
		8'h9F
	};

	localparam logic [7:0] COMBINED_ROM [MAP_ENTRIES] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h81, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h82, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h83, 8'h2A,
		8'h85, 8'h20, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
		8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h9E,
		8'h9F
	};

	// classified word passed from front to back
	typedef struct packed {
		logic             key_valid;
		logic             is_pause;
		logic [IDX_W-1:0] idx;
		logic             use_combined;
		logic             key_make;
		logic             extended;
		logic             led_update;
		logic             caps_led;
		logic             num_led;
		logic             scroll_led;
	} sc2a_word_t;

	function automatic logic [7:0] rom_normal(input logic [IDX_W-1:0] idx);
		logic [7:0] code;
		code = CODE_NONE;
		if (int'(idx) < MAP_ENTRIES) begin
			code = NORMAL_ROM[idx];
		end
		return code;
	endfunction

	function automatic logic [7:0] rom_combined(input logic [IDX_W-1:0] idx);
		logic [7:0] code;
		code = CODE_NONE;
		if (int'(idx) < MAP_ENTRIES) begin
			code = COMBINED_ROM[idx];
		end
		return code;
	endfunction

endpackage

/* design/sc2a_front.sv */
// ----------------------------------------------------------------------------
// sc2a_front
// takes scan bytes, tracks prefix and lock state, classifies each byte
// ----------------------------------------------------------------------------
module sc2a_front #(
	parameter logic [1:0] PAUSE_SKIP = sc2a_pkg::PAUSE_SKIP_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          scan_code,
	output logic                push,
	input  logic                q_ready,
	output sc2a_pkg::sc2a_word_t word
);
	import sc2a_pkg::*;

	logic       shift_q, caps_q, num_q, scroll_q, ext_pend_q;
	logic [1:0] skip_q;

	logic       shift_d, caps_d, num_d, scroll_d, ext_pend_d;
	logic [1:0] skip_d;
	logic [IDX_W-1:0] idx;
	logic       down, skipping, pause_byte, ext_byte, plain, letter, comb, led;
	logic [7:0] norm_code;

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready;

	assign idx        = scan_code[IDX_W-1:0];
	assign down       = !scan_code[7];
	assign skipping   = (skip_q != 2'd0);
	assign pause_byte = !skipping && (scan_code == SC_PAUSE_PREFIX);
	assign ext_byte   = !skipping && (scan_code == SC_EXTEND_PREFIX);
	assign plain      = !skipping && !pause_byte && !ext_byte;
	assign norm_code  = rom_normal(idx);
	assign letter     = (norm_code inside {[ASCII_LOWER_A:ASCII_LOWER_Z]});

	always_comb begin
		if (letter) begin
			comb = shift_q ^ caps_q;
		end else if (idx inside {[IDX_SYM_FIRST:IDX_SYM_LAST]}) begin
			comb = shift_q;
		end else if ((idx inside {[IDX_KP_FIRST:IDX_KP_LAST]}) && !ext_pend_q) begin
			comb = num_q;
		end else begin
			comb = 1'b0;
		end
	end

	always_comb begin
		shift_d    = shift_q;
		caps_d     = caps_q;
		num_d      = num_q;
		scroll_d   = scroll_q;
		ext_pend_d = ext_pend_q;
		skip_d     = skip_q;
		led        = 1'b0;
		if (skipping) begin
			skip_d = skip_q - 2'd1;
		end else if (pause_byte) begin
			skip_d = PAUSE_SKIP;
		end else if (ext_byte) begin
			ext_pend_d = 1'b1;
		end else begin
			ext_pend_d = 1'b0;
			if (idx == IDX_LSHIFT || idx == IDX_RSHIFT) begin
				shift_d = down;
			end else if (idx == IDX_CAPS && down) begin
				caps_d = !caps_q;
				led    = 1'b1;
			end else if (idx == IDX_NUM && down) begin
				num_d = !num_q;
				led   = 1'b1;
			end else if (idx == IDX_SCROLL && down) begin
				scroll_d = !scroll_q;
				led      = 1'b1;
			end
		end
	end

	always_comb begin
		word.key_valid    = pause_byte || plain;
		word.is_pause     = pause_byte;
		word.idx          = idx;
		word.use_combined = comb;
		word.key_make     = pause_byte || (plain && down);
		word.extended     = plain && ext_pend_q;
		word.led_update   = led;
		word.caps_led     = caps_d;
		word.num_led      = num_d;
		word.scroll_led   = scroll_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= 1'b0;
			caps_q     <= 1'b0;
			num_q      <= 1'b0;
			scroll_q   <= 1'b0;
			ext_pend_q <= 1'b0;
			skip_q     <= 2'd0;
		end else if (push) begin
			shift_q    <= shift_d;
			caps_q     <= caps_d;
			num_q      <= num_d;
			scroll_q   <= scroll_d;
			ext_pend_q <= ext_pend_d;
			skip_q     <= skip_d;
		end
	end

endmodule

/* design/sc2a_queue.sv */
// ----------------------------------------------------------------------------
// sc2a_queue
// short word queue between the classifying front and the lookup back
// ----------------------------------------------------------------------------
`include "scan_code_to_ascii_converter_core_defines.svh"

module sc2a_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                push_ready,
	input  sc2a_pkg::sc2a_word_t push_word,
	output logic                pop_valid,
	input  logic                pop,
	output sc2a_pkg::sc2a_word_t pop_word
);
	import sc2a_pkg::*;

	localparam logic [QCNT_W-1:0] FULL     = QCNT_W'(QUEUE_DEPTH);
	localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

	sc2a_word_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_word   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SC2A_ASSERT_NEVER(a_count_range, count_q > FULL, "queue count beyond depth")
	`SC2A_ASSERT_IMPL(a_no_pop_empty, pop, count_q != '0, "pop from empty queue")
	`SC2A_ASSERT_NEXT(a_count_hold, !push && !pop, $stable(count_q), "count moved while idle")

endmodule

/* design/sc2a_back.sv */
// ----------------------------------------------------------------------------
// sc2a_back
// key map lookup and registered result stage
// ----------------------------------------------------------------------------
module sc2a_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                word_valid,
	output logic                pop,
	input  sc2a_pkg::sc2a_word_t word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                key_valid,
	output logic [7:0]          key_code,
	output logic                key_make,
	output logic                extended,
	output logic                led_update,
	output logic                caps_led,
	output logic                num_led,
	output logic                scroll_led
);
	import sc2a_pkg::*;

	logic       out_valid_q;
	logic [7:0] code;
	logic       key_valid_q, key_make_q, extended_q, led_update_q;
	logic       caps_q, num_q, scroll_q;
	logic [7:0] key_code_q;

	assign pop = word_valid && (!out_valid_q || out_ready);

	always_comb begin
		if (!word.key_valid) begin
			code = CODE_NONE;
		end else if (word.is_pause) begin
			code = CODE_PAUSE;
		end else if (word.use_combined) begin
			code = rom_combined(word.idx);
		end else begin
			code = rom_normal(word.idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			key_valid_q  <= word.key_valid;
			key_code_q   <= code;
			key_make_q   <= word.key_make;
			extended_q   <= word.extended;
			led_update_q <= word.led_update;
			caps_q       <= word.caps_led;
			num_q        <= word.num_led;
			scroll_q     <= word.scroll_led;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_valid  = key_valid_q;
	assign key_code   = key_code_q;
	assign key_make   = key_make_q;
	assign extended   = extended_q;
	assign led_update = led_update_q;
	assign caps_led   = caps_q;
	assign num_led    = num_q;
	assign scroll_led = scroll_q;

endmodule

/* design/scan_code_to_ascii_converter_core.sv */
// ----------------------------------------------------------------------------
// scan_code_to_ascii_converter_core
// set-1 scan byte to key code converter with shift and lock tracking
//
//   channel   handshake              payload
//   input     in_valid / in_ready    scan_code
//   output    out_valid / out_ready  key_valid key_code key_make extended
//                                    led_update caps_led num_led scroll_led
//
// one word per cycle sustained while out_ready is held high; a byte that is
// taken goes from front classify into a queue entry, then to the registered lookup
// every byte gives exactly one output word, prefix and skipped bytes included
// reset clears lock, shift, prefix and pause skip state and empties the queue
// the two-entry queue and output register take up an output stall; in_ready
// drops only once both are full
// ----------------------------------------------------------------------------
module scan_code_to_ascii_converter_core #(
	parameter logic [1:0] PAUSE_SKIP = sc2a_pkg::PAUSE_SKIP_COUNT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       key_valid,
	output logic [7:0] key_code,
	output logic       key_make,
	output logic       extended,
	output logic       led_update,
	output logic       caps_led,
	output logic       num_led,
	output logic       scroll_led
);
	import sc2a_pkg::*;

	sc2a_word_t front_word, back_word;
	logic       push, q_ready, q_valid, pop;

	sc2a_front #(
		.PAUSE_SKIP(PAUSE_SKIP)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.scan_code(scan_code),
		.push     (push),
		.q_ready  (q_ready),
		.word     (front_word)
	);

	sc2a_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(q_ready),
		.push_word (front_word),
		.pop_valid (q_valid),
		.pop       (pop),
		.pop_word  (back_word)
	);

	sc2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_valid(q_valid),
		.pop       (pop),
		.word      (back_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_valid (key_valid),
		.key_code  (key_code),
		.key_make  (key_make),
		.extended  (extended),
		.led_update(led_update),
		.caps_led  (caps_led),
		.num_led   (num_led),
		.scroll_led(scroll_led)
	);

endmodule

/* tb/scan_code_to_ascii_converter_core_test.sv */
// ----------------------------------------------------------------------------
// scan_code_to_ascii_converter_core_test
// drives set-1 scan bytes into the converter and checks every output word
// against a predictor that tracks shift, lock, prefix and pause skip state;
// runs directed key sequences, then random keyboard traffic under three
// idle mixes, with one long output stall that backs the block up
// ----------------------------------------------------------------------------
module scan_code_to_ascii_converter_core_test;
	import sc2a_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD   = 80;

	localparam logic [7:0] PLAIN_KEYS [MAP_ENTRIES] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h81, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h83, 8'h2A,
		8'h85, 8'h20, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
		8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93,
		8'h94, 8'h95, 8'h2D, 8'h96, 8'h97, 8'h98, 8'h2B, 8'h99,
		8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h00, 8'h00, 8'h00, 8'h9E,
		8'h9F
	};

	localparam logic [7:0] SHIFTED_KEYS [MAP_ENTRIES] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h81, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h82, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h83, 8'h2A,
		8'h85, 8'h20, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
		8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h9E,
		8'h9F
	};

	localparam logic [7:0] DIRECTED_SCANS [26] = '{
		8'h00, 8'hFF, 8'h1E, 8'h2A, 8'h1E, 8'h02, 8'h3A, 8'hBA,
		8'h1E, 8'hAA, 8'h45, 8'h47, SC_EXTEND_PREFIX, 8'h47,
		SC_EXTEND_PREFIX, 8'hB6, 8'h46, SC_PAUSE_PREFIX, 8'h1D, 8'h45,
		8'h59, SC_EXTEND_PREFIX, SC_PAUSE_PREFIX, 8'h1D, 8'h9D, 8'h1C
	};

	typedef struct packed {
		logic       key_valid;
		logic [7:0] key_code;
		logic       key_make;
		logic       extended;
		logic       led_update;
		logic       caps_led;
		logic       num_led;
		logic       scroll_led;
	} key_word_t;

	class key_decode_tracker;
		key_word_t  expected_words[$];
		logic       shift_held, caps_on, num_on, scroll_on, ext_pending;
		logic [1:0] skip_left;
		int         errors, words, led_updates, pauses, ext_codes;

		function new();
			shift_held = 0; caps_on = 0; num_on = 0; scroll_on = 0;
			ext_pending = 0; skip_left = 0;
			errors = 0; words = 0; led_updates = 0; pauses = 0; ext_codes = 0;
		endfunction

		function logic [7:0] lookup(input logic [6:0] idx);
			logic [7:0] plain;
			logic       use_shifted;
			if (int'(idx) >= MAP_ENTRIES) return CODE_NONE;
			plain = PLAIN_KEYS[idx];
			if (plain >= ASCII_LOWER_A && plain <= ASCII_LOWER_Z)
				use_shifted = shift_held ^ caps_on;
			else if (idx >= IDX_SYM_FIRST && idx <= IDX_SYM_LAST)
				use_shifted = shift_held;
			else if (idx >= IDX_KP_FIRST && idx <= IDX_KP_LAST && !ext_pending)
				use_shifted = num_on;
			else
				use_shifted = 0;
			return use_shifted ? SHIFTED_KEYS[idx] : plain;
		endfunction

		function void note_scan(input logic [7:0] sc);
			key_word_t  w;
			logic [6:0] idx;
			logic       down;
			w = '0;
			idx = sc[6:0];
			down = ~sc[7];
			if (skip_left != 0) begin
				skip_left = skip_left - 2'd1;
			end else if (sc == SC_PAUSE_PREFIX) begin
				w.key_valid = 1;
				w.key_code = CODE_PAUSE;
				w.key_make = 1;
				skip_left = PAUSE_SKIP_COUNT;
				pauses++;
			end else if (sc == SC_EXTEND_PREFIX) begin
				ext_pending = 1;
			end else begin
				w.key_valid = 1;
				w.key_code = lookup(idx);
				w.extended = ext_pending;
				w.key_make = down;
				ext_codes += ext_pending;
				ext_pending = 0;
				if (idx == IDX_LSHIFT || idx == IDX_RSHIFT) begin
					shift_held = down;
				end else if (idx == IDX_CAPS && down) begin
					caps_on = ~caps_on;
					w.led_update = 1;
				end else if (idx == IDX_NUM && down) begin
					num_on = ~num_on;
					w.led_update = 1;
				end else if (idx == IDX_SCROLL && down) begin
					scroll_on = ~scroll_on;
					w.led_update = 1;
				end
				led_updates += w.led_update;
			end
			w.caps_led = caps_on;
			w.num_led = num_on;
			w.scroll_led = scroll_on;
			expected_words.push_back(w);
		endfunction

		function void compare(input string name, input logic [7:0] want, input logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %02h, got %02h", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(input key_word_t got);
			key_word_t want;
			if (expected_words.size() == 0) begin
				$error("key word with none pending: %p", got);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			words++;
			compare("key_valid", 8'(want.key_valid), 8'(got.key_valid));
			compare("key_code", want.key_code, got.key_code);
			compare("key_make", 8'(want.key_make), 8'(got.key_make));
			compare("extended", 8'(want.extended), 8'(got.extended));
			compare("led_update", 8'(want.led_update), 8'(got.led_update));
			compare("caps_led", 8'(want.caps_led), 8'(got.caps_led));
			compare("num_led", 8'(want.num_led), 8'(got.num_led));
			compare("scroll_led", 8'(want.scroll_led), 8'(got.scroll_led));
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] scan_code;
	logic       out_valid;
	logic       out_ready;
	logic       key_valid;
	logic [7:0] key_code;
	logic       key_make;
	logic       extended;
	logic       led_update;
	logic       caps_led;
	logic       num_led;
	logic       scroll_led;

	key_decode_tracker tracker = new();
	int in_count = 0;
	int in_idle_pct = 6;
	int out_idle_pct = 64;
	bit hold_request = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	scan_code_to_ascii_converter_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scan_code  (scan_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_valid  (key_valid),
		.key_code   (key_code),
		.key_make   (key_make),
		.extended   (extended),
		.led_update (led_update),
		.caps_led   (caps_led),
		.num_led    (num_led),
		.scroll_led (scroll_led)
	);

	always #6 clk = ~clk;

	// output side: random stalls plus one long hold on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_word({key_valid, key_code, key_make, extended, led_update,
					caps_led, num_led, scroll_led});
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else if (hold_request) begin
				hold_request = 0;
				hold_left = LONG_HOLD;
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_scan(input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		scan_code <= b;
		do @(posedge clk); while (!in_ready);
		tracker.note_scan(b);
		in_count++;
	endtask

	task automatic key_tap(input logic [6:0] idx, input bit ext);
		if (ext) send_scan(SC_EXTEND_PREFIX);
		send_scan({1'b0, idx});
		if (ext) send_scan(SC_EXTEND_PREFIX);
		send_scan({1'b1, idx});
	endtask

	task automatic random_burst();
		int         pick;
		int         n;
		logic [6:0] k;
		pick = $urandom_range(99);
		if (pick < 40) begin
			key_tap(7'($urandom_range(MAP_ENTRIES - 1)), 1'b0);
		end else if (pick < 52) begin
			key_tap(7'($urandom_range(127)), 1'($urandom_range(1)));
		end else if (pick < 64) begin
			k = $urandom_range(1) ? IDX_LSHIFT : IDX_RSHIFT;
			send_scan({1'b0, k});
			n = $urandom_range(4, 1);
			repeat (n) key_tap(7'($urandom_range(IDX_SYM_LAST, IDX_SYM_FIRST)), 1'b0);
			send_scan({1'b1, k});
		end else if (pick < 74) begin
			case ($urandom_range(2))
				0: k = IDX_CAPS;
				1: k = IDX_NUM;
				default: k = IDX_SCROLL;
			endcase
			key_tap(k, 1'b0);
		end else if (pick < 84) begin
			key_tap(7'($urandom_range(IDX_KP_LAST, IDX_KP_FIRST)), 1'($urandom_range(1)));
		end else if (pick < 90) begin
			// full pause make/break sequence
			send_scan(SC_PAUSE_PREFIX);
			send_scan(8'h1D);
			send_scan(8'h45);
			send_scan(SC_PAUSE_PREFIX);
			send_scan(8'h9D);
			send_scan(8'hC5);
		end else begin
			send_scan(8'($urandom_range(255)));
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (tracker.expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int count, input int in_pct, input int out_pct);
		int start;
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		start = in_count;
		while (in_count - start < count) random_burst();
		drain();
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		scan_code = 0;
		out_ready = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (DIRECTED_SCANS[i]) send_scan(DIRECTED_SCANS[i]);
		drain();
		run_phase(220, 6, 64);
		run_phase(220, 64, 6);
		// sender keeps offering while the output is held off
		hold_request = 1;
		run_phase(240, 0, 0);
		repeat (8) @(posedge clk);
		$display("sent %0d scan bytes under three idle mixes and a long output stall",
			in_count);
		$display("checked %0d words: %0d lock toggles, %0d pause keys, %0d extended codes",
			tracker.words, tracker.led_updates, tracker.pauses, tracker.ext_codes);
		if (tracker.errors == 0 && tracker.expected_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
